/* src/hsv_color_vote_classifier_assert.svh */
// Assertion macros shared by the colour vote classifier RTL.
`ifndef HSV_COLOR_VOTE_CLASSIFIER_ASSERT_SVH
`define HSV_COLOR_VOTE_CLASSIFIER_ASSERT_SVH

// Concurrent check on a given clock, disabled while the active-low reset is low.
`define HSVC_ASSERT_CLK(label, clk_sig, rstn_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error(msg);

// Concurrent check on the block's own clock and reset.
`define HSVC_ASSERT(label, prop, msg) \
    `HSVC_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

/* src/hsvc_pkg.sv */
// Package for the HSV colour vote classifier: widths, classes and thresholds.
package hsvc_pkg;

    // Vote counter width and width of the count fields on the result channel
    localparam int COUNT_BITS = 20;
    localparam int VOTE_BITS  = 20;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam int NUM_CLASSES = 5;

    // Pixel classes, in priority order, white last
    typedef enum logic [2:0] {
        CLS_RED    = 3'd0,
        CLS_BLUE   = 3'd1,
        CLS_GREEN  = 3'd2,
        CLS_YELLOW = 3'd3,
        CLS_WHITE  = 3'd4
    } color_t;

    // Hue ranges, all bounds inclusive, on the 0..180 scale
    localparam logic [7:0] RED_HUE_LOW_MAX  = 8'd10;
    localparam logic [7:0] RED_HUE_HIGH_MIN = 8'd160;
    localparam logic [7:0] HUE_MAX          = 8'd180;
    localparam logic [7:0] BLUE_HUE_MIN     = 8'd106;
    localparam logic [7:0] BLUE_HUE_MAX     = 8'd126;
    localparam logic [7:0] GREEN_HUE_MIN    = 8'd60;
    localparam logic [7:0] GREEN_HUE_MAX    = 8'd102;
    localparam logic [7:0] YELLOW_HUE_MIN   = 8'd10;
    localparam logic [7:0] YELLOW_HUE_MAX   = 8'd50;

    // Saturation and brightness floors
    localparam logic [7:0] RED_SAT_MIN    = 8'd60;
    localparam logic [7:0] RED_VAL_MIN    = 8'd50;
    localparam logic [7:0] BLUE_SAT_MIN   = 8'd60;
    localparam logic [7:0] BLUE_VAL_MIN   = 8'd90;
    localparam logic [7:0] GREEN_SAT_MIN  = 8'd85;
    localparam logic [7:0] GREEN_VAL_MIN  = 8'd40;
    localparam logic [7:0] YELLOW_SAT_MIN = 8'd60;
    localparam logic [7:0] YELLOW_VAL_MIN = 8'd50;

    // Classify one pixel; the first matching range wins
    function automatic color_t classify(input logic [7:0] h, input logic [7:0] s,
                                        input logic [7:0] v);
        color_t c;
        if ((h <= RED_HUE_LOW_MAX || (h >= RED_HUE_HIGH_MIN && h <= HUE_MAX))
            && s >= RED_SAT_MIN && v >= RED_VAL_MIN)
            c = CLS_RED;
        else if (h >= BLUE_HUE_MIN && h <= BLUE_HUE_MAX
                 && s >= BLUE_SAT_MIN && v >= BLUE_VAL_MIN)
            c = CLS_BLUE;
        else if (h >= GREEN_HUE_MIN && h <= GREEN_HUE_MAX
                 && s >= GREEN_SAT_MIN && v >= GREEN_VAL_MIN)
            c = CLS_GREEN;
        else if (h >= YELLOW_HUE_MIN && h <= YELLOW_HUE_MAX
                 && s >= YELLOW_SAT_MIN && v >= YELLOW_VAL_MIN)
            c = CLS_YELLOW;
        else
            c = CLS_WHITE;
        return c;
    endfunction

endpackage

/* src/hsv_color_vote_classifier.sv */
// Top level of the HSV colour vote classifier: classify, count votes, report winner.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one HSV pixel per beat with the
//   object slot and a last_pixel flag closing the object's region. Each pixel
//   is classified red, blue, green, yellow or white and its saturating vote
//   counter advances. On the last pixel the result channel (out_valid/out_ready)
//   presents the slot, the winning colour among red, blue, green and yellow
//   (ties go to the earlier colour) and all five counts; the counters then clear.
//   A last pixel is held in the classification register, then loads the result
//   register and raises out_valid; a stalled result can hold it in between.
//   Throughput: one pixel per cycle while in_ready is high.
//   Reset clears the counters and both valid flags.
//   A stalled receiver holds the result; pixels that are not last keep flowing,
//   and only a second last pixel waits in the classification register, which
//   then drops in_ready until the result beat is taken.
module hsv_color_vote_classifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] hue,
    input  logic [7:0] saturation,
    input  logic [7:0] brightness,
    input  logic [2:0] object_id,
    input  logic       last_pixel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  object_slot,
    output logic [1:0]  winning_color,
    output logic [hsvc_pkg::VOTE_BITS-1:0] red_votes,
    output logic [hsvc_pkg::VOTE_BITS-1:0] blue_votes,
    output logic [hsvc_pkg::VOTE_BITS-1:0] green_votes,
    output logic [hsvc_pkg::VOTE_BITS-1:0] yellow_votes,
    output logic [hsvc_pkg::VOTE_BITS-1:0] white_votes
);
    import hsvc_pkg::*;

    `include "hsv_color_vote_classifier_assert.svh"

    // Classification stage
    logic       s1_valid_reg;
    color_t     s1_cls_reg;
    logic [2:0] s1_obj_reg;
    logic       s1_last_reg;
    logic       s1_advance;
    logic       in_fire;

    // Vote counters
    logic [COUNT_BITS-1:0] count_reg  [NUM_CLASSES];
    logic [COUNT_BITS-1:0] count_next [NUM_CLASSES];
    logic [COUNT_BITS-1:0] count_inc  [NUM_CLASSES];

    // Result register
    logic                 out_valid_reg;
    logic [2:0]           obj_out_reg;
    color_t               win_out_reg;
    logic [VOTE_BITS-1:0] votes_out_reg [NUM_CLASSES];
    color_t               win_next;
    logic [COUNT_BITS-1:0] win_count;
    logic [VOTE_BITS-1:0]  win_votes;

    // Terms for the checks
    logic result_load;
    logic counts_clear;
    logic winner_is_max;
    logic result_blocked;

    // Stage advances unless it holds a last pixel and the result is stalled
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    // Hold the classified pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cls_reg  <= classify(hue, saturation, brightness);
            s1_obj_reg  <= object_id;
            s1_last_reg <= last_pixel;
        end
    end

    // Bump the matching counter, saturating at full scale
    always_comb
    begin
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            count_inc[i] = count_reg[i];
            if (s1_cls_reg == color_t'(i) && count_reg[i] != COUNT_MAX)
                count_inc[i] = count_reg[i] + COUNT_BITS'(1);
        end
    end

    // Pick the winner among the four colours, earlier colour on a tie
    always_comb
    begin
        win_next  = CLS_RED;
        win_count = count_inc[CLS_RED];
        if (count_inc[CLS_BLUE] > win_count)
        begin
            win_next  = CLS_BLUE;
            win_count = count_inc[CLS_BLUE];
        end
        if (count_inc[CLS_GREEN] > win_count)
        begin
            win_next  = CLS_GREEN;
            win_count = count_inc[CLS_GREEN];
        end
        if (count_inc[CLS_YELLOW] > win_count)
        begin
            win_next  = CLS_YELLOW;
            win_count = count_inc[CLS_YELLOW];
        end
    end

    // Clear the counters once a last pixel has been counted
    always_comb
    begin
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            if (!s1_advance)
                count_next[i] = count_reg[i];
            else if (s1_last_reg)
                count_next[i] = '0;
            else
                count_next[i] = count_inc[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
                count_reg[i] <= count_next[i];
        end
    end

    // Load the result beat on a last pixel, drop it when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
        begin
            obj_out_reg <= s1_obj_reg;
            win_out_reg <= win_next;
            for (int i = 0; i < NUM_CLASSES; i++)
                votes_out_reg[i] <= VOTE_BITS'(count_inc[i]);
        end
    end

    assign out_valid     = out_valid_reg;
    assign object_slot   = obj_out_reg;
    assign winning_color = win_out_reg[1:0];
    assign red_votes     = votes_out_reg[CLS_RED];
    assign blue_votes    = votes_out_reg[CLS_BLUE];
    assign green_votes   = votes_out_reg[CLS_GREEN];
    assign yellow_votes  = votes_out_reg[CLS_YELLOW];
    assign white_votes   = votes_out_reg[CLS_WHITE];
    assign win_votes     = votes_out_reg[win_out_reg];

    // Gather the conditions the checks below look at
    assign result_load    = s1_advance && s1_last_reg;
    assign counts_clear   = count_reg[CLS_RED] == '0 && count_reg[CLS_BLUE] == '0
                            && count_reg[CLS_GREEN] == '0 && count_reg[CLS_YELLOW] == '0
                            && count_reg[CLS_WHITE] == '0;
    assign winner_is_max  = win_votes >= red_votes && win_votes >= blue_votes
                            && win_votes >= green_votes && win_votes >= yellow_votes;
    assign result_blocked = s1_valid_reg && s1_last_reg && out_valid_reg && !out_ready;

    // A new result beat only follows a last pixel leaving the classification stage
    `HSVC_ASSERT(a_result_from_last, $rose(out_valid_reg) |-> $past(result_load), "stray result")
    // Counters are clear after a last pixel has been counted
    `HSVC_ASSERT(a_counts_cleared, result_load |=> counts_clear, "counters not cleared")
    // The reported winner holds at least as many votes as each of red, blue, green and yellow
    `HSVC_ASSERT(a_winner_max, out_valid_reg |-> winner_is_max, "winner not largest")
    // Input stalls only behind a second last pixel waiting on a stalled result
    `HSVC_ASSERT(a_stall_cause, !in_ready |-> result_blocked, "input stalled without cause")

endmodule

/* sim/hsv_color_vote_classifier_tb.sv */
// Testbench for the HSV colour vote classifier: predicts each object's vote tally and checks it.
`timescale 1ns / 1ps

module hsv_color_vote_classifier_tb;
    import hsvc_pkg::*;

    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int RANDOM_PER_PHASE = 375;
    localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic [2:0] id;
        logic       is_last;
    } pixel_t;

    typedef struct packed {
        logic [2:0]                            slot;
        logic [1:0]                            winner;
        logic [NUM_CLASSES-1:0][VOTE_BITS-1:0] votes;
    } tally_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] hue = '0;
    logic [7:0] saturation = '0;
    logic [7:0] brightness = '0;
    logic [2:0] object_id = '0;
    logic last_pixel = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] object_slot;
    logic [1:0] winning_color;
    logic [VOTE_BITS-1:0] red_votes;
    logic [VOTE_BITS-1:0] blue_votes;
    logic [VOTE_BITS-1:0] green_votes;
    logic [VOTE_BITS-1:0] yellow_votes;
    logic [VOTE_BITS-1:0] white_votes;

    pixel_t pending_pixels[$];
    tally_t expected_tallies[$];
    logic [COUNT_BITS-1:0] vote_tally [NUM_CLASSES];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int pixels_accepted = 0;
    int objects_checked = 0;
    int wins [4] = '{0, 0, 0, 0};
    int cycle_count = 0;

    hsv_color_vote_classifier dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .hue           (hue),
        .saturation    (saturation),
        .brightness    (brightness),
        .object_id     (object_id),
        .last_pixel    (last_pixel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .object_slot   (object_slot),
        .winning_color (winning_color),
        .red_votes     (red_votes),
        .blue_votes    (blue_votes),
        .green_votes   (green_votes),
        .yellow_votes  (yellow_votes),
        .white_votes   (white_votes)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sort a pixel into its colour class; first matching range wins
    function automatic color_t sort_pixel(input logic [7:0] h, input logic [7:0] s,
                                          input logic [7:0] v);
        color_t c;
        c = CLS_WHITE;
        if (s >= YELLOW_SAT_MIN && v >= YELLOW_VAL_MIN
            && h >= YELLOW_HUE_MIN && h <= YELLOW_HUE_MAX)
            c = CLS_YELLOW;
        if (s >= GREEN_SAT_MIN && v >= GREEN_VAL_MIN
            && h >= GREEN_HUE_MIN && h <= GREEN_HUE_MAX)
            c = CLS_GREEN;
        if (s >= BLUE_SAT_MIN && v >= BLUE_VAL_MIN
            && h >= BLUE_HUE_MIN && h <= BLUE_HUE_MAX)
            c = CLS_BLUE;
        if (s >= RED_SAT_MIN && v >= RED_VAL_MIN
            && (h <= RED_HUE_LOW_MAX || (h >= RED_HUE_HIGH_MIN && h <= HUE_MAX)))
            c = CLS_RED;
        return c;
    endfunction

    // Count one accepted pixel; on the last pixel queue the object's tally and clear
    task automatic tally_pixel(input pixel_t px);
        color_t c;
        color_t w;
        tally_t t;
        c = sort_pixel(px.hue, px.sat, px.val);
        if (vote_tally[c] != TALLY_MAX)
            vote_tally[c] = vote_tally[c] + COUNT_BITS'(1);
        if (px.is_last)
        begin
            w = CLS_RED;
            for (int k = CLS_BLUE; k <= CLS_YELLOW; k++)
            begin
                if (vote_tally[k] > vote_tally[w])
                    w = color_t'(k);
            end
            t.slot = px.id;
            t.winner = w[1:0];
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                t.votes[k] = vote_tally[k][VOTE_BITS-1:0];
                vote_tally[k] = '0;
            end
            expected_tallies = {expected_tallies, t};
        end
    endtask

    task automatic push_pixel(input int h, input int s, input int v, input int id,
                              input bit is_last);
        pixel_t px;
        px.hue = h[7:0];
        px.sat = s[7:0];
        px.val = v[7:0];
        px.id = id[2:0];
        px.is_last = is_last;
        pending_pixels = {pending_pixels, px};
    endtask

    // Pick a pixel aimed at one range edge, or anywhere
    task automatic push_random_pixel(input int kind, input int id, input bit is_last);
        int h;
        int s;
        int v;
        case (kind)
            0: h = $urandom_range(12, 0);
            1: h = $urandom_range(183, 157);
            2: h = $urandom_range(129, 103);
            3: h = $urandom_range(105, 57);
            4: h = $urandom_range(53, 8);
            7: h = $urandom_range(255, 181);
            default: h = $urandom_range(255, 0);
        endcase
        s = $urandom_range(1) ? $urandom_range(95, 50) : $urandom_range(255, 0);
        v = $urandom_range(1) ? $urandom_range(100, 30) : $urandom_range(255, 0);
        push_pixel(h, s, v, id, is_last);
    endtask

    // Hold until every pixel is taken and every tally has come back
    task automatic drain();
        while (pending_pixels.size() != 0 || in_valid || expected_tallies.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string what, input logic [VOTE_BITS-1:0] want,
                               input logic [VOTE_BITS-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Pixel driver: hold a beat until taken, then advance or idle
    always @(posedge clk)
    begin : drive_pixels
        pixel_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                tally_pixel({hue, saturation, brightness, object_id, last_pixel});
                pixels_accepted++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_pixels.pop_front();
                    hue <= nxt.hue;
                    saturation <= nxt.sat;
                    brightness <= nxt.val;
                    object_id <= nxt.id;
                    last_pixel <= nxt.is_last;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each result beat with the oldest expected tally
    always @(posedge clk)
    begin : watch_tallies
        tally_t want;
        string vote_name [NUM_CLASSES];
        logic [VOTE_BITS-1:0] got_votes [NUM_CLASSES];
        vote_name = '{"red_votes", "blue_votes", "green_votes", "yellow_votes",
                      "white_votes"};
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_tallies.size() == 0)
                begin
                    $display("%0t: result with no object pending, slot %0d", $time,
                             object_slot);
                    errors++;
                end
                else
                begin
                    want = expected_tallies.pop_front();
                    got_votes = '{red_votes, blue_votes, green_votes, yellow_votes,
                                  white_votes};
                    check_field("object_slot", VOTE_BITS'(want.slot),
                                VOTE_BITS'(object_slot));
                    check_field("winning_color", VOTE_BITS'(want.winner),
                                VOTE_BITS'(winning_color));
                    for (int k = 0; k < NUM_CLASSES; k++)
                        check_field(vote_name[k], want.votes[k], got_votes[k]);
                    objects_checked++;
                    wins[want.winner]++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                     cycle_count, expected_tallies.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int pushed;
        int len;
        int dom;
        int id;
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 46, 0, 13};
        recv_pct = '{0, 0, 46, 13};
        for (int k = 0; k < NUM_CLASSES; k++)
            vote_tally[k] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Range edges and priority: red at its floors, red over yellow at hue 10
        push_pixel(0, 60, 50, 0, 1);
        push_pixel(10, 255, 255, 1, 0);
        push_pixel(11, 60, 50, 1, 0);
        push_pixel(50, 60, 50, 1, 1);
        // Upper red band, hue past 180 and missing floors vote white
        push_pixel(180, 60, 50, 2, 0);
        push_pixel(181, 255, 255, 2, 0);
        push_pixel(255, 255, 255, 2, 0);
        push_pixel(159, 255, 255, 2, 0);
        push_pixel(160, 59, 255, 2, 0);
        push_pixel(5, 255, 49, 2, 1);
        // Blue edges and its brightness floor
        push_pixel(106, 60, 90, 3, 0);
        push_pixel(126, 255, 255, 3, 0);
        push_pixel(127, 255, 255, 3, 0);
        push_pixel(110, 255, 89, 3, 1);
        // Green edges, saturation floor, gap between yellow and green
        push_pixel(60, 85, 40, 4, 0);
        push_pixel(102, 255, 255, 4, 0);
        push_pixel(103, 255, 255, 4, 0);
        push_pixel(80, 84, 255, 4, 0);
        push_pixel(51, 60, 50, 4, 0);
        push_pixel(100, 255, 39, 4, 1);
        // Ties go to the earlier colour; an all-white object reports red
        push_pixel(0, 255, 255, 5, 0);
        push_pixel(120, 255, 255, 5, 1);
        push_pixel(115, 200, 200, 6, 0);
        push_pixel(70, 200, 200, 6, 1);
        push_pixel(70, 200, 200, 7, 0);
        push_pixel(30, 200, 200, 7, 1);
        push_pixel(0, 0, 0, 7, 1);
        // Blue against yellow on a tie goes to blue
        push_pixel(30, 255, 255, 5, 0);
        push_pixel(116, 255, 255, 2, 1);
        drain();

        // Random objects, one idling pattern per phase, full drain in between
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pct[p];
            recv_stall_pct = recv_pct[p];
            pushed = 0;
            while (pushed < RANDOM_PER_PHASE)
            begin
                case ($urandom_range(19))
                    0: len = $urandom_range(200, 61);
                    1, 2, 3, 4: len = $urandom_range(60, 13);
                    default: len = $urandom_range(12, 1);
                endcase
                dom = $urandom_range(7);
                id = $urandom_range(7);
                for (int i = 0; i < len; i++)
                    push_random_pixel(($urandom_range(99) < 60) ? dom : $urandom_range(7),
                                      id, i == len - 1);
                pushed += len;
            end
            drain();
        end

        // Let any stray result beat show up before closing
        repeat (8) @(posedge clk);
        $display("Run covered %0d pixels and %0d objects: range edges, then four idling phases",
                 pixels_accepted, objects_checked);
        $display("of random objects; winners red %0d, blue %0d, green %0d, yellow %0d",
                 wins[0], wins[1], wins[2], wins[3]);
        if (errors == 0 && expected_tallies.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/hsvc_pkg.sv
src/hsv_color_vote_classifier.sv
sim/hsv_color_vote_classifier_tb.sv
